@@ src/rti_pkg.sv @@
package rti_pkg;

  // coordinate and result widths
  localparam int COORD_W = 32;
  localparam int PARAM_W = 32;
  localparam int PARAM_FRAC_BITS = 31;

  // internal widths: edges, cross products, dot products
  localparam int EDGE_W = COORD_W + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int LO_W = 32;
  localparam int HI_W = CROSS_W - LO_W;
  localparam int PLO_W = EDGE_W + LO_W + 1;
  localparam int PHI_W = EDGE_W + HI_W;
  localparam int WIDE_W = 104;

  // pipeline depths
  localparam int FRONT_STAGES = 8;
  localparam int DIV_STAGES = PARAM_FRAC_BITS + 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_SPAN_X   = 3'd3,
    REG_SPAN_Y   = 3'd4,
    REG_SPAN_Z   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex0_x;
    logic signed [COORD_W-1:0] vertex0_y;
    logic signed [COORD_W-1:0] vertex0_z;
    logic signed [COORD_W-1:0] vertex1_x;
    logic signed [COORD_W-1:0] vertex1_y;
    logic signed [COORD_W-1:0] vertex1_z;
    logic signed [COORD_W-1:0] vertex2_x;
    logic signed [COORD_W-1:0] vertex2_y;
    logic signed [COORD_W-1:0] vertex2_z;
  } in_item_t;

  typedef struct packed {
    logic               hit_found;
    logic [PARAM_W-1:0] hit_param;
  } out_item_t;

  // ray setup shared by the front end
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] span_x;
    logic signed [COORD_W-1:0] span_y;
    logic signed [COORD_W-1:0] span_z;
  } ray_t;

  // front end to divider
  typedef struct packed {
    logic              hit;
    logic [WIDE_W-1:0] den;
    logic [WIDE_W-1:0] num;
  } div_item_t;

endpackage

@@ src/rti_front.sv @@
module rti_front (
  input  logic               clk,
  input  logic               rst_n,
  input  rti_pkg::ray_t      ray,
  input  logic               up_valid,
  output logic               up_stall,
  input  rti_pkg::in_item_t  up_data,
  output logic               dn_valid,
  input  logic               dn_stall,
  output rti_pkg::div_item_t dn_data
);
  import rti_pkg::*;

  // stage valid bits and per-stage advance
  logic [FRONT_STAGES-1:0] v_r;
  logic [FRONT_STAGES-1:0] mv;

  always_comb begin
    mv[FRONT_STAGES-1] = !v_r[FRONT_STAGES-1] || !dn_stall;
    for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
      mv[k] = !v_r[k] || mv[k+1];
    end
  end

  assign up_stall = !mv[0];
  assign dn_valid = v_r[FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (mv[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (mv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // span widened to edge width
  logic signed [EDGE_W-1:0] sp [3];
  assign sp[0] = {ray.span_x[COORD_W-1], ray.span_x};
  assign sp[1] = {ray.span_y[COORD_W-1], ray.span_y};
  assign sp[2] = {ray.span_z[COORD_W-1], ray.span_z};

  // stage 1: edge vectors and origin offset
  logic signed [EDGE_W-1:0] e1_nxt [3];
  logic signed [EDGE_W-1:0] e2_nxt [3];
  logic signed [EDGE_W-1:0] so_nxt [3];
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [EDGE_W-1:0] so_r [3];

  function automatic logic signed [EDGE_W-1:0] diff(logic signed [COORD_W-1:0] a,
                                                    logic signed [COORD_W-1:0] b);
    diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  always_comb begin
    e1_nxt[0] = diff(up_data.vertex1_x, up_data.vertex0_x);
    e1_nxt[1] = diff(up_data.vertex1_y, up_data.vertex0_y);
    e1_nxt[2] = diff(up_data.vertex1_z, up_data.vertex0_z);
    e2_nxt[0] = diff(up_data.vertex2_x, up_data.vertex0_x);
    e2_nxt[1] = diff(up_data.vertex2_y, up_data.vertex0_y);
    e2_nxt[2] = diff(up_data.vertex2_z, up_data.vertex0_z);
    so_nxt[0] = diff(ray.origin_x, up_data.vertex0_x);
    so_nxt[1] = diff(ray.origin_y, up_data.vertex0_y);
    so_nxt[2] = diff(ray.origin_z, up_data.vertex0_z);
  end

  // stage 2: cross product terms, h = span x e2, q = s x e1
  logic signed [PROD_W-1:0] hp_nxt [6];
  logic signed [PROD_W-1:0] qp_nxt [6];
  logic signed [PROD_W-1:0] hp_r [6];
  logic signed [PROD_W-1:0] qp_r [6];
  logic signed [EDGE_W-1:0] e1_2r [3];
  logic signed [EDGE_W-1:0] e2_2r [3];
  logic signed [EDGE_W-1:0] so_2r [3];

  always_comb begin
    hp_nxt[0] = sp[1] * e2_r[2];
    hp_nxt[1] = sp[2] * e2_r[1];
    hp_nxt[2] = sp[2] * e2_r[0];
    hp_nxt[3] = sp[0] * e2_r[2];
    hp_nxt[4] = sp[0] * e2_r[1];
    hp_nxt[5] = sp[1] * e2_r[0];
    qp_nxt[0] = so_r[1] * e1_r[2];
    qp_nxt[1] = so_r[2] * e1_r[1];
    qp_nxt[2] = so_r[2] * e1_r[0];
    qp_nxt[3] = so_r[0] * e1_r[2];
    qp_nxt[4] = so_r[0] * e1_r[1];
    qp_nxt[5] = so_r[1] * e1_r[0];
  end

  // stage 3: cross product differences
  logic signed [CROSS_W-1:0] h_nxt [3];
  logic signed [CROSS_W-1:0] q_nxt [3];
  logic signed [CROSS_W-1:0] h_r [3];
  logic signed [CROSS_W-1:0] q_r [3];
  logic signed [EDGE_W-1:0]  e1_3r [3];
  logic signed [EDGE_W-1:0]  e2_3r [3];
  logic signed [EDGE_W-1:0]  so_3r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_nxt[i] = $signed({hp_r[2*i][PROD_W-1], hp_r[2*i]})
               - $signed({hp_r[2*i+1][PROD_W-1], hp_r[2*i+1]});
      q_nxt[i] = $signed({qp_r[2*i][PROD_W-1], qp_r[2*i]})
               - $signed({qp_r[2*i+1][PROD_W-1], qp_r[2*i+1]});
    end
  end

  // stage 4: split dot products into low and high partial products
  // dot 0 det = e1.h, 1 un = s.h, 2 vn = span.q, 3 tn = e2.q
  logic signed [EDGE_W-1:0]  da [4][3];
  logic signed [CROSS_W-1:0] db [4][3];
  logic signed [PLO_W-1:0]   pl_nxt [4][3];
  logic signed [PHI_W-1:0]   ph_nxt [4][3];
  logic signed [PLO_W-1:0]   pl_r [4][3];
  logic signed [PHI_W-1:0]   ph_r [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da[0][i] = e1_3r[i];
      db[0][i] = h_r[i];
      da[1][i] = so_3r[i];
      db[1][i] = h_r[i];
      da[2][i] = sp[i];
      db[2][i] = q_r[i];
      da[3][i] = e2_3r[i];
      db[3][i] = q_r[i];
    end
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 3; i++) begin
        pl_nxt[d][i] = da[d][i] * $signed({1'b0, db[d][i][LO_W-1:0]});
        ph_nxt[d][i] = da[d][i] * $signed(db[d][i][CROSS_W-1:LO_W]);
      end
    end
  end

  // stage 5: recombine partial products
  logic signed [WIDE_W-1:0] tm_nxt [4][3];
  logic signed [WIDE_W-1:0] tm_r [4][3];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 3; i++) begin
        tm_nxt[d][i] = ($signed({{(WIDE_W-PHI_W){ph_r[d][i][PHI_W-1]}}, ph_r[d][i]}) <<< LO_W)
                     + $signed({{(WIDE_W-PLO_W){pl_r[d][i][PLO_W-1]}}, pl_r[d][i]});
      end
    end
  end

  // stage 6: dot product sums
  logic signed [WIDE_W-1:0] sm_nxt [4];
  logic signed [WIDE_W-1:0] sm_r [4];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      sm_nxt[d] = tm_r[d][0] + tm_r[d][1] + tm_r[d][2];
    end
  end

  // stage 7: move the sign of det onto the numerators
  logic signed [WIDE_W-1:0] ng_nxt [4];
  logic signed [WIDE_W-1:0] ng_r [4];
  logic                     nz_nxt;
  logic                     nz_r;

  always_comb begin
    nz_nxt = (sm_r[0] != '0);
    for (int d = 0; d < 4; d++) begin
      ng_nxt[d] = sm_r[0][WIDE_W-1] ? -sm_r[d] : sm_r[d];
    end
  end

  // stage 8: triangle and segment bounds
  logic signed [WIDE_W-1:0] uv_sum;
  div_item_t                dv_nxt;
  div_item_t                dv_r;

  always_comb begin
    uv_sum = ng_r[1] + ng_r[2];
    dv_nxt.hit = nz_r && !ng_r[1][WIDE_W-1] && !ng_r[2][WIDE_W-1] && !ng_r[3][WIDE_W-1]
              && (uv_sum <= ng_r[0]) && (ng_r[3] <= ng_r[0]);
    dv_nxt.den = ng_r[0];
    dv_nxt.num = ng_r[3];
  end

  assign dn_data = dv_r;

  // data registers
  always_ff @(posedge clk) begin
    if (mv[0]) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      so_r <= so_nxt;
    end
    if (mv[1]) begin
      hp_r  <= hp_nxt;
      qp_r  <= qp_nxt;
      e1_2r <= e1_r;
      e2_2r <= e2_r;
      so_2r <= so_r;
    end
    if (mv[2]) begin
      h_r   <= h_nxt;
      q_r   <= q_nxt;
      e1_3r <= e1_2r;
      e2_3r <= e2_2r;
      so_3r <= so_2r;
    end
    if (mv[3]) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
    if (mv[4]) begin
      tm_r <= tm_nxt;
    end
    if (mv[5]) begin
      sm_r <= sm_nxt;
    end
    if (mv[6]) begin
      ng_r <= ng_nxt;
      nz_r <= nz_nxt;
    end
    if (mv[7]) begin
      dv_r <= dv_nxt;
    end
  end

endmodule

@@ src/rti_div.sv @@
module rti_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  rti_pkg::div_item_t up_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rti_pkg::out_item_t out_data
);
  import rti_pkg::*;

  // stage valid bits and per-stage advance
  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES-1:0] mv;

  always_comb begin
    mv[DIV_STAGES-1] = !v_r[DIV_STAGES-1] || !out_stall;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      mv[k] = !v_r[k] || mv[k+1];
    end
  end

  assign up_stall  = !mv[0];
  assign out_valid = v_r[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (mv[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (mv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // one restoring quotient bit per stage
  logic [WIDE_W-1:0]  rem_r [DIV_STAGES];
  logic [WIDE_W-1:0]  den_r [DIV_STAGES];
  logic [PARAM_W-1:0] quo_r [DIV_STAGES];
  logic               hit_r [DIV_STAGES];
  logic [WIDE_W-1:0]  rem_nxt [DIV_STAGES];
  logic [PARAM_W-1:0] quo_nxt [DIV_STAGES];
  logic [WIDE_W-1:0]  trial [DIV_STAGES];
  logic               ge [DIV_STAGES];

  always_comb begin
    trial[0]   = up_data.num;
    ge[0]      = (trial[0] >= up_data.den);
    rem_nxt[0] = ge[0] ? trial[0] - up_data.den : trial[0];
    quo_nxt[0] = {{(PARAM_W-1){1'b0}}, ge[0]};
    for (int k = 1; k < DIV_STAGES; k++) begin
      trial[k]   = {rem_r[k-1][WIDE_W-2:0], 1'b0};
      ge[k]      = (trial[k] >= den_r[k-1]);
      rem_nxt[k] = ge[k] ? trial[k] - den_r[k-1] : trial[k];
      quo_nxt[k] = {quo_r[k-1][PARAM_W-2:0], ge[k]};
    end
    // a miss reports a zero parameter
    if (!hit_r[DIV_STAGES-2]) begin
      quo_nxt[DIV_STAGES-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv[0]) begin
      rem_r[0] <= rem_nxt[0];
      den_r[0] <= up_data.den;
      quo_r[0] <= quo_nxt[0];
      hit_r[0] <= up_data.hit;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (mv[k]) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_r[k-1];
        quo_r[k] <= quo_nxt[k];
        hit_r[k] <= hit_r[k-1];
      end
    end
  end

  assign out_data.hit_found = hit_r[DIV_STAGES-1];
  assign out_data.hit_param = quo_r[DIV_STAGES-1];

endmodule

@@ src/ray_triangle_intersection.sv @@
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// in       | in_valid, in_stall, in_data             | item in
// out      | out_valid, out_stall, out_data          | item out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// one item per cycle while out_stall is low; 8 arithmetic stages plus one
// quotient bit per stage over 32 divider stages
// synchronous active-low reset clears all valid bits and the ray registers
// a stall only holds the stages that are full; empty stages keep filling
// cfg_ready is always high, writes take effect on the next cycle
module ray_triangle_intersection (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rti_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rti_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rti_pkg::COORD_W-1:0]         cfg_data
);
  import rti_pkg::*;

  // ray registers
  ray_t ray_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: ray_r.origin_x <= cfg_data;
        REG_ORIGIN_Y: ray_r.origin_y <= cfg_data;
        REG_ORIGIN_Z: ray_r.origin_z <= cfg_data;
        REG_SPAN_X:   ray_r.span_x   <= cfg_data;
        REG_SPAN_Y:   ray_r.span_y   <= cfg_data;
        REG_SPAN_Z:   ray_r.span_z   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front end to divider
  logic      mid_valid;
  logic      mid_stall;
  div_item_t mid_data;

  rti_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ray      (ray_r),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (mid_valid),
    .dn_stall (mid_stall),
    .dn_data  (mid_data)
  );

  rti_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (mid_valid),
    .up_stall  (mid_stall),
    .up_data   (mid_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
